@@ hdl/pise_pkg.sv @@
// pise_pkg: shared constants, types and codes of the pair insert-size estimator
// depends on nothing; every other file imports it
`default_nettype none
package pise_pkg;
	localparam int DEF_BIN_DEPTH = 4096;
	localparam int SPAN_W = 31;
	localparam int NBINS = 3;
	localparam int CNT_OUT_W = 13;
	localparam int STAT_W = 39;
	localparam int FX_FRAC = 8;
	localparam int TRIM_K = 5;
	localparam int DIV3_SH = 21;
	localparam logic [19:0] DIV3_MUL = 20'hAAAAB;
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW = 2;

	typedef enum logic {CMD_ADD = 1'b0, CMD_FINAL = 1'b1} cmd_t;
	typedef enum logic [1:0] {BIN_INNIE = 2'd0, BIN_OUTTIE = 2'd1, BIN_SAME = 2'd2} bin_t;

	typedef struct packed {
		cmd_t cmd;
		bin_t bin;
		logic [SPAN_W-1:0] span;
	} work_t;

	typedef enum logic [1:0] {MOP_MUL = 2'd0, MOP_DIV = 2'd1, MOP_SQRT = 2'd2} mop_t;

	typedef struct packed {
		logic start;
		mop_t op;
	} mctl_t;

	typedef enum logic [3:0] {
		B_IDLE, B_LOAD, B_DIV3A, B_DIV3B, B_SEL, B_SPREAD, B_RANGE, B_SUM,
		B_MEAN, B_KSXX, B_SQX, B_KK, B_VAR, B_SQRT, B_OUT
	} bst_t;

	function automatic int math_w(int depth);
		return 2 * SPAN_W + 2 * FX_FRAC + 2 * $clog2(depth + 1);
	endfunction
endpackage
`default_nettype wire

@@ hdl/pise_ifs.sv @@
// pise_in_if / pise_out_if: valid-ready channels for pair items and bin reports
// depends on pise_pkg
`default_nettype none
interface pise_in_if;
	import pise_pkg::*;
	logic valid;
	logic ready;
	logic cmd;
	logic [SPAN_W-1:0] first_begin;
	logic [SPAN_W-1:0] first_end;
	logic first_reverse;
	logic [SPAN_W-1:0] second_begin;
	logic [SPAN_W-1:0] second_end;
	logic second_reverse;
	modport source(output valid, cmd, first_begin, first_end, first_reverse,
		second_begin, second_end, second_reverse, input ready);
	modport sink(input valid, cmd, first_begin, first_end, first_reverse,
		second_begin, second_end, second_reverse, output ready);
endinterface

interface pise_out_if;
	import pise_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] bin_id;
	logic [CNT_OUT_W-1:0] sample_count;
	logic [STAT_W-1:0] mean_distance;
	logic [STAT_W-1:0] std_deviation;
	logic bin_overflow;
	logic last_result;
	modport source(output valid, bin_id, sample_count, mean_distance, std_deviation,
		bin_overflow, last_result, input ready);
	modport sink(input valid, bin_id, sample_count, mean_distance, std_deviation,
		bin_overflow, last_result, output ready);
endinterface
`default_nettype wire

@@ hdl/pair_insert_size_estimator.sv @@
// pair_insert_size_estimator: top level; front classifier, queue, back statistics, arith unit
// add item: queued, then filed into its bin when the back pops it; one add item per cycle
// while the back is idle; finalize: each non-empty bin takes 31 radix passes and one sum pass
// over memory, then the bit-serial arith unit of width W = 78 + 2*ceil(log2(BIN_DEPTH+1)),
// plus report stalls; an empty bin goes straight to its report; input fills the 4-entry queue
// reset clears fills, overflow marks and control; the span memory is not cleared
`default_nettype none
module pair_insert_size_estimator #(
	parameter int BIN_DEPTH = pise_pkg::DEF_BIN_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	pise_in_if.sink pair,
	pise_out_if.source report
);
	import pise_pkg::*;
	localparam int W = math_w(BIN_DEPTH);

	logic push, full, pop, empty, mdone;
	work_t wk_in, wk_out;
	mctl_t mctl;
	logic [W-1:0] ma, mb, mres;

	pise_front u_front (
		.pair(pair), .full(full), .push(push), .wk(wk_in)
	);

	pise_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wk_in), .full(full),
		.pop(pop), .rdata(wk_out), .empty(empty)
	);

	pise_arith #(.W(W)) u_arith (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb), .done(mdone), .res(mres)
	);

	pise_back #(.BIN_DEPTH(BIN_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .wk(wk_out), .empty(empty), .pop(pop),
		.mctl(mctl), .ma(ma), .mb(mb), .mdone(mdone), .mres(mres), .report(report)
	);
endmodule
`default_nettype wire

@@ hdl/pise_front.sv @@
// pise_front: takes pair items, computes the span and the orientation bin
// depends on pise_pkg, pise_ifs
`default_nettype none
module pise_front (
	pise_in_if.sink pair,
	input  logic full,
	output logic push,
	output pise_pkg::work_t wk
);
	import pise_pkg::*;

	logic [SPAN_W-1:0] hi, lo;
	bin_t bin;

	always_comb begin
		hi = (pair.first_end > pair.second_end) ? pair.first_end : pair.second_end;
		lo = (pair.first_begin < pair.second_begin) ? pair.first_begin : pair.second_begin;
		if (pair.first_reverse == pair.second_reverse) begin
			bin = BIN_SAME;
		end else if ((!pair.first_reverse && pair.first_begin <= pair.second_begin) ||
				(pair.first_reverse && pair.first_begin >= pair.second_begin)) begin
			bin = BIN_INNIE;
		end else begin
			bin = BIN_OUTTIE;
		end
		wk.cmd = cmd_t'(pair.cmd);
		wk.bin = bin;
		wk.span = (hi > lo) ? hi - lo : '0;
	end

	assign pair.ready = !full;
	assign push = pair.valid && !full;
endmodule
`default_nettype wire

@@ hdl/pise_fifo.sv @@
// pise_fifo: short queue of classified items between front and back
// depends on pise_pkg
`default_nettype none
module pise_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pise_pkg::work_t wdata,
	output logic full,
	input  logic pop,
	output pise_pkg::work_t rdata,
	output logic empty
);
	import pise_pkg::*;

	work_t slot_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wp_q, rp_q;
	logic [FQ_AW:0] cnt_q;

	assign full = cnt_q == (FQ_AW+1)'(FQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

@@ hdl/pise_arith.sv @@
// pise_arith: shared multi-cycle unit for shift-add multiply, restoring divide, square root
// depends on pise_pkg
`default_nettype none
module pise_arith #(
	parameter int W = pise_pkg::math_w(pise_pkg::DEF_BIN_DEPTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  pise_pkg::mctl_t ctl,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic done,
	output logic [W-1:0] res
);
	import pise_pkg::*;
	localparam int CNTW = $clog2(W + 1);

	logic busy_q, done_q;
	mop_t op_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0] acc_q, aa_q, bb_q;
	logic [W:0] rem_q, tdiv, tsq, trial_sq;
	logic ge_div, ge_sq;

	always_comb begin
		tdiv = {rem_q[W-1:0], aa_q[W-1]};
		tsq = {rem_q[W-2:0], aa_q[W-1:W-2]};
		trial_sq = {acc_q[W-2:0], 2'b01};
		ge_div = tdiv >= {1'b0, bb_q};
		ge_sq = tsq >= trial_sq;
	end

	assign done = done_q;
	assign res = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= MOP_MUL;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q <= ctl.op;
			cnt_q <= (ctl.op == MOP_SQRT) ? CNTW'(W / 2) : CNTW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			aa_q <= a;
			bb_q <= b;
			rem_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				MOP_MUL: begin
					if (bb_q[0]) acc_q <= acc_q + aa_q;
					aa_q <= aa_q << 1;
					bb_q <= bb_q >> 1;
				end
				MOP_DIV: begin
					if (ge_div) begin
						rem_q <= tdiv - {1'b0, bb_q};
						acc_q <= {acc_q[W-2:0], 1'b1};
					end else begin
						rem_q <= tdiv;
						acc_q <= {acc_q[W-2:0], 1'b0};
					end
					aa_q <= aa_q << 1;
				end
				MOP_SQRT: begin
					if (ge_sq) begin
						rem_q <= tsq - trial_sq;
						acc_q <= {acc_q[W-2:0], 1'b1};
					end else begin
						rem_q <= tsq;
						acc_q <= {acc_q[W-2:0], 1'b0};
					end
					aa_q <= aa_q << 2;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/pise_back.sv @@
// pise_back: span memory, bin fills, radix selection of median and terciles,
// trimmed sums and the statistics sequence; drives the report channel
// depends on pise_pkg, pise_ifs
`default_nettype none
module pise_back #(
	parameter int BIN_DEPTH = pise_pkg::DEF_BIN_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  pise_pkg::work_t wk,
	input  logic empty,
	output logic pop,
	output pise_pkg::mctl_t mctl,
	output logic [pise_pkg::math_w(BIN_DEPTH)-1:0] ma,
	output logic [pise_pkg::math_w(BIN_DEPTH)-1:0] mb,
	input  logic mdone,
	input  logic [pise_pkg::math_w(BIN_DEPTH)-1:0] mres,
	pise_out_if.source report
);
	import pise_pkg::*;
	localparam int CW = $clog2(BIN_DEPTH + 1);
	localparam int RW = CW + 1;
	localparam int MDEPTH = NBINS * BIN_DEPTH;
	localparam int MAW = $clog2(MDEPTH);
	localparam int SXW = SPAN_W + CW;
	localparam int SQW = 2 * SPAN_W + CW;
	localparam int W = math_w(BIN_DEPTH);
	localparam int LW = SPAN_W + 5;

	logic [SPAN_W-1:0] mem [MDEPTH];

	bst_t state_q, state_d;
	bin_t bin_q;
	logic [CW-1:0] fill_q [NBINS];
	logic [NBINS-1:0] marks_q;
	logic go_q, go_d, v_s1, keep_s2;

	logic [CW-1:0] n_q, idx_q, k_q;
	logic [CW-1:0] rank_q [3];
	logic [CW-1:0] cnt_q [3];
	logic [SPAN_W-1:0] pfx_q [3];
	logic [SPAN_W-1:0] mhi_q, bsel_q, rd_s1, x_s2, spread_q;
	logic [2*SPAN_W-1:0] sq_s2;
	logic [SXW-1:0] sx_q;
	logic [SQW-1:0] sxx_q;
	logic signed [LW-1:0] lo_q, hi_q, xs;
	logic [W-1:0] t_q, d_q;
	logic [STAT_W-1:0] mean_q, sd_q;

	logic issue, pass_end, sum_end, wr_en, inr;
	logic [MAW-1:0] raddr, waddr;
	logic [SPAN_W-1:0] gap_lo, gap_hi;
	logic [RW+19:0] d3_lo, d3_hi;

	function automatic logic [MAW-1:0] bin_base(bin_t b);
		logic [MAW-1:0] r;
		unique case (b)
			BIN_INNIE:  r = '0;
			BIN_OUTTIE: r = MAW'(BIN_DEPTH);
			BIN_SAME:   r = MAW'(2 * BIN_DEPTH);
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic is_math(bst_t s);
		return s == B_MEAN || s == B_KSXX || s == B_SQX || s == B_KK ||
			s == B_VAR || s == B_SQRT;
	endfunction

	always_comb begin
		issue = (state_q == B_SEL || state_q == B_SUM) && idx_q != n_q;
		pass_end = state_q == B_SEL && idx_q == n_q && !v_s1;
		sum_end = state_q == B_SUM && idx_q == n_q && !v_s1 && !keep_s2;
		wr_en = pop && wk.cmd == CMD_ADD && fill_q[wk.bin] < CW'(BIN_DEPTH);
		raddr = bin_base(bin_q) + MAW'(idx_q);
		waddr = bin_base(wk.bin) + MAW'(fill_q[wk.bin]);
		xs = LW'(rd_s1);
		inr = xs >= lo_q && xs <= hi_q;
		gap_lo = pfx_q[0] - pfx_q[1];
		gap_hi = pfx_q[2] - pfx_q[0];
		// divide by three through the reciprocal
		d3_lo = (RW+20)'(n_q) * (RW+20)'(DIV3_MUL);
		d3_hi = (RW+20)'({n_q, 1'b0}) * (RW+20)'(DIV3_MUL);
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		mctl.op = MOP_MUL;
		ma = '0;
		mb = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (wk.cmd == CMD_FINAL) state_d = B_LOAD;
				end
			end
			B_LOAD: state_d = (fill_q[bin_q] == '0) ? B_OUT : B_DIV3A;
			B_DIV3A: state_d = B_DIV3B;
			B_DIV3B: state_d = B_SEL;
			B_SEL: if (pass_end && bsel_q[0]) state_d = B_SPREAD;
			B_SPREAD: state_d = B_RANGE;
			B_RANGE: state_d = B_SUM;
			B_SUM: if (sum_end) state_d = (k_q == '0) ? B_OUT : B_MEAN;
			B_MEAN: begin
				mctl.op = MOP_DIV;
				ma = W'(sx_q) << FX_FRAC;
				mb = W'(k_q);
				if (mdone) state_d = (k_q < CW'(2)) ? B_OUT : B_KSXX;
			end
			B_KSXX: begin
				mctl.op = MOP_MUL;
				ma = W'(sxx_q);
				mb = W'(k_q);
				if (mdone) state_d = B_SQX;
			end
			B_SQX: begin
				mctl.op = MOP_MUL;
				ma = W'(sx_q);
				mb = W'(sx_q);
				if (mdone) state_d = B_KK;
			end
			B_KK: begin
				mctl.op = MOP_MUL;
				ma = W'(k_q);
				mb = W'(k_q - 1'b1);
				if (mdone) state_d = B_VAR;
			end
			B_VAR: begin
				mctl.op = MOP_DIV;
				ma = t_q;
				mb = d_q;
				if (mdone) state_d = B_SQRT;
			end
			B_SQRT: begin
				mctl.op = MOP_SQRT;
				ma = t_q;
				if (mdone) state_d = B_OUT;
			end
			B_OUT: if (report.ready) state_d = (bin_q == BIN_SAME) ? B_IDLE : B_LOAD;
			default: state_d = B_IDLE;
		endcase
		go_d = state_d != state_q && is_math(state_d);
		mctl.start = go_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			bin_q <= BIN_INNIE;
			for (int i = 0; i < NBINS; i++) fill_q[i] <= '0;
			marks_q <= '0;
			go_q <= 1'b0;
			v_s1 <= 1'b0;
			keep_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q <= go_d;
			v_s1 <= issue;
			keep_s2 <= v_s1 && state_q == B_SUM && inr;
			if (pop && wk.cmd == CMD_FINAL) bin_q <= BIN_INNIE;
			if (pop && wk.cmd == CMD_ADD) begin
				if (wr_en) fill_q[wk.bin] <= fill_q[wk.bin] + 1'b1;
				else marks_q[wk.bin] <= 1'b1;
			end
			if (state_q == B_OUT && report.ready && bin_q != BIN_SAME)
				bin_q <= bin_t'(bin_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wk.span;
		rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		x_s2 <= rd_s1;
		sq_s2 <= rd_s1 * rd_s1;
		if (issue) idx_q <= idx_q + 1'b1;
		unique case (state_q)
			B_LOAD: begin
				n_q <= fill_q[bin_q];
				rank_q[0] <= fill_q[bin_q] >> 1;
				idx_q <= '0;
				k_q <= '0;
				sx_q <= '0;
				sxx_q <= '0;
				mean_q <= '0;
				sd_q <= '0;
				mhi_q <= '0;
				bsel_q <= {1'b1, {(SPAN_W-1){1'b0}}};
				for (int j = 0; j < 3; j++) begin
					pfx_q[j] <= '0;
					cnt_q[j] <= '0;
				end
			end
			B_DIV3A: rank_q[1] <= CW'(d3_lo >> DIV3_SH);
			B_DIV3B: rank_q[2] <= CW'(d3_hi >> DIV3_SH);
			B_SEL: begin
				if (v_s1) begin
					for (int j = 0; j < 3; j++) begin
						if (((rd_s1 ^ pfx_q[j]) & mhi_q) == '0 && (rd_s1 & bsel_q) == '0)
							cnt_q[j] <= cnt_q[j] + 1'b1;
					end
				end
				if (pass_end) begin
					for (int j = 0; j < 3; j++) begin
						if (rank_q[j] >= cnt_q[j]) begin
							pfx_q[j] <= pfx_q[j] | bsel_q;
							rank_q[j] <= rank_q[j] - cnt_q[j];
						end
						cnt_q[j] <= '0;
					end
					idx_q <= '0;
					mhi_q <= mhi_q | bsel_q;
					bsel_q <= bsel_q >> 1;
				end
			end
			B_SPREAD: spread_q <= (gap_lo > gap_hi) ? gap_lo : gap_hi;
			B_RANGE: begin
				lo_q <= LW'(pfx_q[0]) - LW'(spread_q) * LW'(TRIM_K);
				hi_q <= LW'(pfx_q[0]) + LW'(spread_q) * LW'(TRIM_K);
			end
			B_SUM: begin
				if (keep_s2) begin
					k_q <= k_q + 1'b1;
					sx_q <= sx_q + SXW'(x_s2);
					sxx_q <= sxx_q + SQW'(sq_s2);
				end
			end
			B_MEAN: if (mdone) mean_q <= STAT_W'(mres);
			B_KSXX: if (mdone) t_q <= mres;
			B_SQX: if (mdone) t_q <= (t_q - mres) << (2 * FX_FRAC);
			B_KK: if (mdone) d_q <= mres;
			B_VAR: if (mdone) t_q <= mres;
			B_SQRT: if (mdone) sd_q <= STAT_W'(mres);
			default: ;
		endcase
	end

	assign report.valid = state_q == B_OUT;
	assign report.bin_id = bin_q;
	assign report.sample_count = CNT_OUT_W'(fill_q[bin_q]);
	assign report.mean_distance = mean_q;
	assign report.std_deviation = sd_q;
	assign report.bin_overflow = marks_q[bin_q];
	assign report.last_result = bin_q == BIN_SAME;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= CW'(BIN_DEPTH) && fill_q[1] <= CW'(BIN_DEPTH) &&
		fill_q[2] <= CW'(BIN_DEPTH))
		else $error("bin fill beyond depth");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && report.ready && bin_q == BIN_SAME |=> state_q == B_IDLE)
		else $error("finalize did not end after last bin");
	a_marks_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(marks_q) & ~marks_q) == '0)
		else $error("overflow mark cleared");
	a_done_in_math: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> is_math(state_q))
		else $error("arith result outside a math step");
endmodule
`default_nettype wire

@@ tb/pair_insert_size_estimator_test.sv @@
// pair_insert_size_estimator_test: self-checking bench with directed and random pair items
// depends on pise_pkg, pise_ifs and pair_insert_size_estimator; predicts bin reports per item
`timescale 1ns / 1ps
module pair_insert_size_estimator_test;
	import pise_pkg::*;

	localparam int DEPTH = DEF_BIN_DEPTH;
	localparam int IDLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 2000;
	localparam logic [30:0] COORD_MAX = 31'h7fffffff;

	typedef struct {
		cmd_t cmd;
		logic [30:0] fb, fe, sb, se;
		logic fr, sr;
	} pair_item_t;

	typedef struct {
		logic [1:0] bin_id;
		logic [12:0] count;
		logic [38:0] mean;
		logic [38:0] sd;
		logic ovf;
		logic last;
	} bin_report_t;

	logic clk;
	logic arst_n;
	pise_in_if pair();
	pise_out_if report();

	pair_insert_size_estimator dut (.clk(clk), .arst_n(arst_n), .pair(pair), .report(report));

	pair_item_t pending_items[$];
	bin_report_t expected_reports[$];
	int unsigned bin_spans[3][$];
	logic [2:0] dropped_marks;
	int mismatches;
	int n_accepted;
	int idle_cycles;
	int hold_left;
	bit hold_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bin_t pair_bin(pair_item_t it);
		if (it.fr == it.sr)
			return BIN_SAME;
		if ((!it.fr && it.fb <= it.sb) || (it.fr && it.fb >= it.sb))
			return BIN_INNIE;
		return BIN_OUTTIE;
	endfunction

	function automatic logic [41:0] isqrt(logic [127:0] v);
		logic [41:0] r;
		logic [127:0] t;
		r = '0;
		for (int b = 41; b >= 0; b--) begin
			t = {86'd0, r | (42'd1 << b)};
			if (t * t <= v)
				r = t[41:0];
		end
		return r;
	endfunction

	function automatic void trimmed_stats(int unsigned vals[$], output logic [38:0] mean,
			output logic [38:0] sd);
		int unsigned s[$];
		int unsigned n, med, lo3, hi3, spread;
		longint lo_lim, hi_lim;
		logic [63:0] k, sx;
		logic [127:0] sxx, num;
		s = vals;
		s.sort();
		n = s.size();
		mean = '0;
		sd = '0;
		if (n == 0)
			return;
		med = s[n / 2];
		lo3 = s[n / 3];
		hi3 = s[(n * 2) / 3];
		spread = (med - lo3 > hi3 - med) ? med - lo3 : hi3 - med;
		lo_lim = longint'(med) - 5 * longint'(spread);
		hi_lim = longint'(med) + 5 * longint'(spread);
		k = 0;
		sx = 0;
		sxx = 0;
		foreach (s[i]) begin
			if (lo_lim <= longint'(s[i]) && longint'(s[i]) <= hi_lim) begin
				k++;
				sx += s[i];
				sxx += 128'(s[i]) * 128'(s[i]);
			end
		end
		if (k == 0)
			return;
		mean = 39'((sx << 8) / k);
		if (k < 2)
			return;
		num = 128'(k) * sxx - 128'(sx) * 128'(sx);
		num = num << 16;
		sd = 39'(isqrt(num / (128'(k) * 128'(k - 1))));
	endfunction

	task automatic predict_pair(pair_item_t it);
		bin_t b;
		logic [30:0] hi, lo;
		int unsigned span;
		bin_report_t r;
		if (it.cmd == CMD_ADD) begin
			hi = (it.fe > it.se) ? it.fe : it.se;
			lo = (it.fb < it.sb) ? it.fb : it.sb;
			span = (hi > lo) ? 32'(hi - lo) : 0;
			b = pair_bin(it);
			if (bin_spans[b].size() >= DEPTH)
				dropped_marks[b] = 1'b1;
			else
				bin_spans[b].insert(bin_spans[b].size(), span);
		end else begin
			for (int i = 0; i < 3; i++) begin
				r.bin_id = 2'(i);
				r.count = 13'(bin_spans[i].size());
				trimmed_stats(bin_spans[i], r.mean, r.sd);
				r.ovf = dropped_marks[i];
				r.last = (i == 2);
				expected_reports.insert(expected_reports.size(), r);
			end
		end
	endtask

	task automatic add_item(pair_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic pair_item_t mk_pair(logic [30:0] fb, fe, logic fr,
			logic [30:0] sb, se, logic sr);
		pair_item_t it;
		it.cmd = CMD_ADD;
		it.fb = fb; it.fe = fe; it.fr = fr;
		it.sb = sb; it.se = se; it.sr = sr;
		return it;
	endfunction

	function automatic pair_item_t mk_final();
		pair_item_t it;
		it = mk_pair(31'($urandom), 31'($urandom), 1'($urandom),
			31'($urandom), 31'($urandom), 1'($urandom));
		it.cmd = CMD_FINAL;
		return it;
	endfunction

	function automatic pair_item_t mk_random_pair();
		logic [30:0] base, len1, len2, ins;
		logic fr;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return mk_pair(31'($urandom), 31'($urandom), 1'($urandom),
				31'($urandom), 31'($urandom), 1'($urandom));
		base = 31'($urandom_range(0, 32'h7ff00000));
		len1 = 31'($urandom_range(80, 150));
		len2 = 31'($urandom_range(80, 150));
		ins = (pick < 20) ? 31'($urandom_range(5000, 100000)) : 31'($urandom_range(200, 600));
		fr = 1'($urandom);
		case ($urandom_range(0, 2))
			0: return mk_pair(base, base + len1, 1'b0, base + ins - len2, base + ins, 1'b1);
			1: return mk_pair(base + ins - len2, base + ins, 1'b1, base, base + len1, 1'b0);
			default: return mk_pair(base, base + len1, fr, base + ins - len2, base + ins, fr);
		endcase
	endfunction

	// sender: drives the next pending item, predicts at each accepted item
	always @(posedge clk or negedge arst_n) begin
		int pct;
		pair_item_t it;
		if (!arst_n) begin
			pair.valid <= 1'b0;
			pair.cmd <= CMD_ADD;
			pair.first_begin <= '0;
			pair.first_end <= '0;
			pair.first_reverse <= 1'b0;
			pair.second_begin <= '0;
			pair.second_end <= '0;
			pair.second_reverse <= 1'b0;
			n_accepted <= 0;
		end else if (!pair.valid || pair.ready) begin
			if (pair.valid) begin
				it.cmd = cmd_t'(pair.cmd);
				it.fb = pair.first_begin; it.fe = pair.first_end; it.fr = pair.first_reverse;
				it.sb = pair.second_begin; it.se = pair.second_end; it.sr = pair.second_reverse;
				predict_pair(it);
				n_accepted <= n_accepted + 1;
			end
			case ((n_accepted / 60) % 4)
				1: pct = 52;
				3: pct = 8;
				default: pct = 0;
			endcase
			if (hold_left > 0)
				pct = 0;
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= pct) begin
				it = pending_items.pop_front();
				pair.valid <= 1'b1;
				pair.cmd <= it.cmd;
				pair.first_begin <= it.fb;
				pair.first_end <= it.fe;
				pair.first_reverse <= it.fr;
				pair.second_begin <= it.sb;
				pair.second_end <= it.se;
				pair.second_reverse <= it.sr;
			end else begin
				pair.valid <= 1'b0;
			end
		end
	end

	// receiver: checks reports in order, stalls at random and once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		int pct;
		bin_report_t e;
		if (!arst_n) begin
			report.ready <= 1'b0;
			mismatches <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (report.valid && report.ready) begin
				if (expected_reports.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected report: bin %0d", report.bin_id);
				end else begin
					e = expected_reports.pop_front();
					if (report.bin_id !== e.bin_id || report.sample_count !== e.count ||
							report.mean_distance !== e.mean || report.std_deviation !== e.sd ||
							report.bin_overflow !== e.ovf || report.last_result !== e.last) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display({"mismatch: exp bin %0d cnt %0d mean %0d sd %0d ovf %0d",
								" last %0d, got bin %0d cnt %0d mean %0d sd %0d ovf %0d last %0d"},
								e.bin_id, e.count, e.mean, e.sd, e.ovf, e.last,
								report.bin_id, report.sample_count, report.mean_distance,
								report.std_deviation, report.bin_overflow, report.last_result);
					end
				end
			end
			if (!hold_done && report.valid && n_accepted > 150) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				report.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				report.ready <= 1'b0;
			end else begin
				case ((n_accepted / 60) % 4)
					2: pct = 52;
					3: pct = 8;
					default: pct = 0;
				endcase
				report.ready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((pair.valid && pair.ready) || (report.valid && report.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		dropped_marks = '0;
		arst_n = 1'b0;
		// empty bins
		add_item(mk_final());
		// single sample in innie, forward first
		add_item(mk_pair(31'd100, 31'd200, 1'b0, 31'd300, 31'd400, 1'b1));
		add_item(mk_final());
		// reverse first, first begin at or above second begin
		add_item(mk_pair(31'd500, 31'd600, 1'b1, 31'd500, 31'd550, 1'b0));
		// outtie both ways
		add_item(mk_pair(31'd900, 31'd1000, 1'b0, 31'd100, 31'd200, 1'b1));
		add_item(mk_pair(31'd100, 31'd200, 1'b1, 31'd900, 31'd1000, 1'b0));
		// same orientation, both polarities
		add_item(mk_pair(31'd0, 31'd10, 1'b0, 31'd5, 31'd20, 1'b0));
		add_item(mk_pair(31'd0, 31'd10, 1'b1, 31'd5, 31'd20, 1'b1));
		// ends below begins gives zero span
		add_item(mk_pair(31'd5000, 31'd10, 1'b0, 31'd6000, 31'd20, 1'b1));
		add_item(mk_pair(31'd0, 31'd0, 1'b1, 31'd0, 31'd0, 1'b0));
		// coordinate extremes
		add_item(mk_pair(31'd0, COORD_MAX, 1'b0, COORD_MAX, COORD_MAX, 1'b1));
		add_item(mk_pair(COORD_MAX, COORD_MAX, 1'b1, 31'd0, COORD_MAX, 1'b0));
		add_item(mk_pair(COORD_MAX, 31'd0, 1'b0, COORD_MAX, 31'd0, 1'b0));
		add_item(mk_pair(31'd0, COORD_MAX, 1'b1, 31'd0, COORD_MAX, 1'b1));
		add_item(mk_final());
		for (int i = 0; i < 280; i++)
			add_item((i % 25 == 24) ? mk_final() : mk_random_pair());
		add_item(mk_pair(31'd10, 31'd20, 1'b0, 31'd30, 31'd40, 1'b1));
		add_item(mk_final());
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0 && !pair.valid);
		wait (expected_reports.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
